// File: rtl/core/sasf_pkg.sv
package sasf_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned ThreshBits = 12;
  localparam int unsigned CountBits  = 8;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 12;

  localparam logic [CfgIdxBits-1:0] CfgIdxThreshold = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgIdxConfirm   = 1'b1;

  localparam logic [ThreshBits-1:0] ThresholdReset = 12'd32;
  localparam logic [CountBits-1:0]  ConfirmReset   = 8'd3;

  typedef logic [SampleBits-1:0] sample_t;

  // Control broadcast along the sample chain.
  typedef struct packed {
    logic shift;
    logic prime;
  } sasf_ctl_t;

  // Smoothed value handed from the averaging stage to the spike filter.
  typedef struct packed {
    logic    valid;
    sample_t value;
  } sasf_smooth_t;

endpackage

// File: rtl/core/sensor_average_spike_filter_top.sv
// Sensor average and spike filter.
// Input channel: in_valid_i/in_ready_o carry one item, a raw sample and a
// restart flag that makes this sample fill the whole averaging window.
// Output channel: out_valid_o/out_ready_i carry one item per input item, the
// spike-filtered reading and the rounded moving average.
// Configuration: cfg_we_i writes the spike threshold (index 0) or the
// confirmation count (index 1) from cfg_wdata_i; write only while idle.
// From the accepting edge to out_valid_o an item passes through three register
// stages: the sample chain and running total, the reciprocal multiply, and
// the spike filter with its output register.
// Throughput is one item per cycle while the receiver does not stall; the
// running total and the spike filter state are each updated once per item.
// Reset clears the pipeline, the averaging and filter state and loads the
// register defaults (threshold 32, confirmation count 3).
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// in the same cycle; nothing is lost or repeated.
module sensor_average_spike_filter_top
  import sasf_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SampleBits-1:0]  sample_i,
  input  logic                   restart_average_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SampleBits-1:0]  filtered_reading_o,
  output logic [SampleBits-1:0]  smoothed_reading_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  logic                  en;
  logic                  accept;
  sasf_smooth_t          smooth;
  logic [ThreshBits-1:0] thresh_q;
  logic [CountBits-1:0]  confirm_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= ThresholdReset;
      confirm_q <= ConfirmReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxThreshold: thresh_q  <= cfg_wdata_i[ThreshBits-1:0];
        CfgIdxConfirm:   confirm_q <= cfg_wdata_i[CountBits-1:0];
        default: ;
      endcase
    end
  end

  sasf_avg #(
    .WINDOW(WINDOW)
  ) u_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .sample_i (sample_i),
    .restart_i(restart_average_i),
    .smooth_o (smooth)
  );

  sasf_spike u_spike (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .smooth_i   (smooth),
    .threshold_i(thresh_q),
    .confirm_i  (confirm_q),
    .valid_o    (out_valid_o),
    .filtered_o (filtered_reading_o),
    .smoothed_o (smoothed_reading_o)
  );

endmodule

// File: rtl/core/sasf_cell.sv
module sasf_cell
  import sasf_pkg::*;
(
  input  logic      clk_i,
  input  sasf_ctl_t ctl_i,
  input  sample_t   prime_data_i,
  input  sample_t   shift_data_i,
  output sample_t   data_o
);

  sample_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      data_q <= ctl_i.prime ? prime_data_i : shift_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/sasf_avg.sv
module sasf_avg
  import sasf_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         accept_i,
  input  sample_t      sample_i,
  input  logic         restart_i,
  output sasf_smooth_t smooth_o
);

  localparam int unsigned MaxSample = (1 << SampleBits) - 1;
  localparam int unsigned TotBits   = $clog2(WINDOW * MaxSample + 1);
  localparam int unsigned Half      = WINDOW / 2;
  localparam int unsigned NumBits   = $clog2(WINDOW * MaxSample + Half + 1);
  localparam int unsigned LogW      = $clog2(WINDOW);
  localparam int unsigned ShiftK    = NumBits + LogW;
  localparam int unsigned MultBits  = NumBits + 1;
  localparam int unsigned ProdBits  = NumBits + MultBits;
  localparam longint unsigned MultL =
    ((longint'(1) << ShiftK) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [MultBits-1:0] Mult = MultBits'(MultL);

  sasf_ctl_t ctl;
  sample_t   cell_q [WINDOW];
  logic      primed_q, primed_d;
  logic [TotBits-1:0]  total_q, total_d;
  logic                s1_valid_q;
  logic [ProdBits-1:0] prod_q;
  logic                s2_valid_q;

  assign ctl.shift = accept_i;
  assign ctl.prime = !primed_q || restart_i;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sasf_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .prime_data_i(sample_i),
      .shift_data_i((i == 0) ? sample_i : cell_q[(i == 0) ? 0 : i - 1]),
      .data_o      (cell_q[i])
    );
  end

  always_comb begin
    primed_d = primed_q;
    total_d  = total_q;
    if (accept_i) begin
      primed_d = 1'b1;
      if (ctl.prime) begin
        total_d = TotBits'(sample_i) * TotBits'(WINDOW);
      end else begin
        total_d = total_q - TotBits'(cell_q[WINDOW-1]) + TotBits'(sample_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      total_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      primed_q <= primed_d;
      total_q  <= total_d;
      if (en_i) begin
        s1_valid_q <= accept_i;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Rounded division by the window as an exact reciprocal multiply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdBits'(NumBits'(total_q) + NumBits'(Half)) * ProdBits'(Mult);
    end
  end

  assign smooth_o.valid = s2_valid_q;
  assign smooth_o.value = prod_q[ShiftK +: SampleBits];

endmodule

// File: rtl/core/sasf_spike.sv
module sasf_spike
  import sasf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  sasf_smooth_t          smooth_i,
  input  logic [ThreshBits-1:0] threshold_i,
  input  logic [CountBits-1:0]  confirm_i,
  output logic                  valid_o,
  output sample_t               filtered_o,
  output sample_t               smoothed_o
);

  logic                 started_q, started_d;
  sample_t              stable_q, stable_d;
  sample_t              pend_q, pend_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [CountBits-1:0] cnt_inc;
  logic                 valid_q;
  sample_t              filt_q, smooth_q;
  sample_t              v;
  logic                 near_stable, near_pend;

  function automatic sample_t abs_diff(sample_t a, sample_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign v           = smooth_i.value;
  assign near_stable = abs_diff(v, stable_q) <= threshold_i;
  assign near_pend   = abs_diff(v, pend_q) <= threshold_i;
  assign cnt_inc     = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    started_d = started_q;
    stable_d  = stable_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    if (!started_q) begin
      started_d = 1'b1;
      stable_d  = v;
      pend_d    = v;
      cnt_d     = '0;
    end else if (near_stable) begin
      stable_d = v;
      cnt_d    = '0;
    end else if (cnt_q == '0 || !near_pend) begin
      pend_d = v;
      cnt_d  = CountBits'(1);
    end else if (cnt_inc >= confirm_i) begin
      stable_d = v;
      cnt_d    = '0;
    end else begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      stable_q  <= '0;
      pend_q    <= '0;
      cnt_q     <= '0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_q <= smooth_i.valid;
      if (smooth_i.valid) begin
        started_q <= started_d;
        stable_q  <= stable_d;
        pend_q    <= pend_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && smooth_i.valid) begin
      filt_q   <= stable_d;
      smooth_q <= v;
    end
  end

  assign valid_o    = valid_q;
  assign filtered_o = filt_q;
  assign smoothed_o = smooth_q;

endmodule

// File: rtl/core/sasf_chk.sv
module sasf_chk
  import sasf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SampleBits-1:0]  filtered_reading_o,
  input logic [SampleBits-1:0]  smoothed_reading_o
);

  logic            seen_q;
  sample_t         last_filt_q;
  logic            in_rst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      last_filt_q <= filtered_reading_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_rst_q <= !rst_ni;
  end

  // A stalled item holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_reading_o)
      && $stable(smoothed_reading_o))
    else $error("output item changed while stalled");

  // A stall on the output side stops input acceptance in the same cycle.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // The stable reading either holds or takes the current smoothed value.
  a_filt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (filtered_reading_o == smoothed_reading_o)
      || (seen_q && filtered_reading_o == last_filt_q))
    else $error("filtered reading from an unexpected source");

  // No output item is shown once reset has been seen at a clock edge.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni && in_rst_q |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind sensor_average_spike_filter_top sasf_chk u_sasf_chk (.*);

// File: sim/sensor_average_spike_filter_top_tb.sv
module sensor_average_spike_filter_top_tb;
  import sasf_pkg::*;

  localparam int Window        = 8;
  localparam int LatencyCycles = 3;
  localparam int CycleLimit    = 200000;
  localparam int HoldCycles    = 200;

  typedef struct packed {
    sample_t sample;
    logic    restart;
  } reading_in_t;

  typedef struct packed {
    sample_t filtered;
    sample_t smoothed;
  } reading_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sample_t                in_sample = '0;
  logic                   in_restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sample_t                filtered_reading;
  sample_t                smoothed_reading;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx = CfgIdxThreshold;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  reading_in_t  pending_q[$];
  reading_out_t expected_q[$];
  reading_in_t  next_item;
  reading_out_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_cnt = 0;
  int cycle_cnt = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;

  // Predictor state.
  sample_t                avg_ring[Window];
  logic [2:0]             avg_pos;
  logic [14:0]            avg_total;
  logic                   avg_primed;
  logic                   flt_started;
  sample_t                flt_stable;
  sample_t                flt_pending;
  logic [CountBits-1:0]   flt_count;
  logic [ThreshBits-1:0]  cur_thresh;
  logic [CountBits-1:0]   cur_confirm;

  sensor_average_spike_filter_top u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .sample_i           (in_sample),
    .restart_average_i  (in_restart),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .filtered_reading_o (filtered_reading),
    .smoothed_reading_o (smoothed_reading),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic reading_out_t filter_predict(reading_in_t it);
    reading_out_t r;
    int unsigned  avg;
    sample_t      v;
    if (it.restart) begin
      for (int i = 0; i < Window; i++) avg_ring[i] = '0;
      avg_pos = '0;
      avg_total = '0;
      avg_primed = 1'b0;
    end
    if (!avg_primed) begin
      for (int i = 0; i < Window; i++) avg_ring[i] = it.sample;
      avg_pos = '0;
      avg_total = 15'(it.sample * Window);
      avg_primed = 1'b1;
      avg = it.sample;
    end else begin
      avg_total = avg_total - 15'(avg_ring[avg_pos]) + 15'(it.sample);
      avg_ring[avg_pos] = it.sample;
      avg_pos = avg_pos + 3'd1;
      avg = (32'(avg_total) + Window / 2) / Window;
    end
    v = sample_t'(avg);
    if (!flt_started) begin
      flt_started = 1'b1;
      flt_stable = v;
      flt_pending = v;
      flt_count = '0;
    end else if (gap(v, flt_stable) <= cur_thresh) begin
      flt_stable = v;
      flt_count = '0;
    end else if (flt_count == 0 || gap(v, flt_pending) > cur_thresh) begin
      flt_pending = v;
      flt_count = 8'd1;
    end else begin
      if (flt_count < 8'd255) flt_count = flt_count + 8'd1;
      if (flt_count >= cur_confirm) begin
        flt_stable = v;
        flt_count = '0;
      end
    end
    r.filtered = flt_stable;
    r.smoothed = v;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_val);
    error_cnt++;
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(filter_predict('{in_sample, in_restart}));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_sample <= next_item.sample;
          in_restart <= next_item.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item, filtered", filtered_reading, 0);
        end else begin
          want = expected_q.pop_front();
          if (filtered_reading !== want.filtered)
            report_mismatch("filtered_reading", filtered_reading, want.filtered);
          if (smoothed_reading !== want.smoothed)
            report_mismatch("smoothed_reading", smoothed_reading, want.smoothed);
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_cnt <= HoldCycles;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("sensor_average_spike_filter_top_tb: errors");
    $finish;
  end

  task automatic add_item(int s, logic restart);
    pending_q.push_back('{sample_t'(s), restart});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (LatencyCycles + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CfgDataBits'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgIdxThreshold) cur_thresh = ThreshBits'(data);
    else cur_confirm = CountBits'(data);
  endtask

  task automatic setup_phase(int thresh, int confirm, int send_pct, int recv_pct);
    wait_idle();
    write_reg(CfgIdxThreshold, thresh);
    write_reg(CfgIdxConfirm, confirm);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic gen_readings(int n, int jit);
    int level;
    int s;
    int r;
    level = $urandom_range(0, 4095);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) level = $urandom_range(0, 4095);
      if (r >= 4 && r < 10) begin
        s = $urandom_range(0, 4095);
      end else if (r == 10) begin
        s = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      end else begin
        s = level + int'($urandom_range(0, 2 * jit)) - jit;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
      end
      add_item(s, $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    int lo;
    int hi;
    int t;
    for (int i = 0; i < Window; i++) avg_ring[i] = '0;
    avg_pos = '0;
    avg_total = '0;
    avg_primed = 1'b0;
    flt_started = 1'b0;
    flt_stable = '0;
    flt_pending = '0;
    flt_count = '0;
    cur_thresh = ThresholdReset;
    cur_confirm = ConfirmReset;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults first: priming, restarts, pending levels and confirmation.
    add_item(4095, 1'b0);
    add_item(4095, 1'b0);
    add_item(0, 1'b1);
    add_item(0, 1'b0);
    add_item(0, 1'b0);
    add_item(20, 1'b0);
    add_item(4095, 1'b0);
    add_item(0, 1'b0);
    add_item(0, 1'b0);
    add_item(2000, 1'b1);
    add_item(2000, 1'b0);
    add_item(2000, 1'b0);
    add_item(2020, 1'b0);
    add_item(1000, 1'b1);
    add_item(3000, 1'b1);
    add_item(3000, 1'b0);
    add_item(3000, 1'b0);
    add_item(7, 1'b1);
    add_item(0, 1'b0);
    add_item(4095, 1'b1);
    add_item(0, 1'b1);
    add_item(4095, 1'b0);
    add_item(2730, 1'b0);
    add_item(1365, 1'b0);

    setup_phase(0, 1, 0, 0);
    add_item(4095, 1'b1);
    add_item(0, 1'b1);
    add_item(0, 1'b0);
    add_item(0, 1'b0);
    gen_readings(200, 2);

    setup_phase(4095, 255, 55, 0);
    gen_readings(150, 200);

    setup_phase(16, 2, 0, 55);
    gen_readings(200, 12);

    setup_phase(64, 4, 14, 14);
    gen_readings(200, 40);

    t = $urandom_range(1, 200);
    setup_phase(t, $urandom_range(1, 10), 14, 14);
    gen_readings(200, t / 2 + 1);

    // A long agreeing run at a new level so the count climbs to the top setting.
    setup_phase(100, 255, 14, 14);
    lo = $urandom_range(0, 1000);
    hi = $urandom_range(3000, 4095);
    add_item(lo, 1'b1);
    for (int i = 0; i < 10; i++) add_item(lo + int'($urandom_range(0, 8)), 1'b0);
    for (int i = 0; i < 270; i++) add_item(hi - int'($urandom_range(0, 8)), 1'b0);

    // Receiver holds off while the sender keeps offering items.
    setup_phase(48, 3, 0, 0);
    gen_readings(150, 30);
    @(negedge clk);
    hold_req = 1'b1;
    while (hold_cnt == 0) @(negedge clk);
    hold_req = 1'b0;

    setup_phase(32, 3, 55, 55);
    gen_readings(150, 20);

    wait_idle();
    repeat (LatencyCycles + 5) @(negedge clk);
    if (expected_q.size() != 0) report_mismatch("items never delivered", 0, expected_q.size());
    if (error_cnt == 0) begin
      $display("sensor_average_spike_filter_top_tb: clean");
    end else begin
      $display("sensor_average_spike_filter_top_tb: errors");
    end
    $finish;
  end

endmodule
